FILE: sv/svalu_pkg.sv
// shared constants, operation codes and pipeline types for the simd vector alu
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package svalu_pkg;

    localparam int MAX_LANES  = 4;
    localparam int LANES      = 4;
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 5;
    localparam int DIV_STAGES = DATA_W;
    // lane pipeline: operand stage, divider stages, result stage
    localparam int LANE_DEPTH = DIV_STAGES + 2;
    // plus the merge stage that drives the output
    localparam int PIPE_DEPTH = LANE_DEPTH + 1;

    localparam int IN_DATA_W  = 2 * MAX_LANES * DATA_W + 2 * MAX_LANES;
    localparam int OUT_BITS   = MAX_LANES * DATA_W + MAX_LANES + 3;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [MAX_LANES-1:0] LANE_MASK = MAX_LANES'((1 << LANES) - 1);

    localparam logic [KIND_W-1:0] K_BCAST  = 5'd0;
    localparam logic [KIND_W-1:0] K_NOT    = 5'd1;
    localparam logic [KIND_W-1:0] K_NEG    = 5'd2;
    localparam logic [KIND_W-1:0] K_ADD    = 5'd3;
    localparam logic [KIND_W-1:0] K_SUB    = 5'd4;
    localparam logic [KIND_W-1:0] K_MUL    = 5'd5;
    localparam logic [KIND_W-1:0] K_DIV    = 5'd6;
    localparam logic [KIND_W-1:0] K_REM    = 5'd7;
    localparam logic [KIND_W-1:0] K_AND    = 5'd8;
    localparam logic [KIND_W-1:0] K_OR     = 5'd9;
    localparam logic [KIND_W-1:0] K_XOR    = 5'd10;
    localparam logic [KIND_W-1:0] K_SHL    = 5'd11;
    localparam logic [KIND_W-1:0] K_SAR    = 5'd12;
    localparam logic [KIND_W-1:0] K_EQ     = 5'd13;
    localparam logic [KIND_W-1:0] K_NE     = 5'd14;
    localparam logic [KIND_W-1:0] K_GE     = 5'd15;
    localparam logic [KIND_W-1:0] K_LE     = 5'd16;
    localparam logic [KIND_W-1:0] K_GT     = 5'd17;
    localparam logic [KIND_W-1:0] K_LT     = 5'd18;
    localparam logic [KIND_W-1:0] K_SEL    = 5'd19;
    localparam logic [KIND_W-1:0] K_MNOT   = 5'd20;
    localparam logic [KIND_W-1:0] K_MAND   = 5'd21;
    localparam logic [KIND_W-1:0] K_MOR    = 5'd22;
    localparam logic [KIND_W-1:0] K_MXOR   = 5'd23;
    localparam logic [KIND_W-1:0] K_MEQ    = 5'd24;
    localparam logic [KIND_W-1:0] K_MNE    = 5'd25;
    localparam logic [KIND_W-1:0] K_MPASS  = 5'd26;

    // per-lane info that rides beside the divider
    typedef struct packed {
        logic [DATA_W-1:0] val;
        logic [DATA_W-1:0] a;
        logic              is_div;
        logic              is_rem;
        logic              dz;
        logic              neg_q;
        logic              neg_r;
    } t_side;

    // per-item control that rides beside the lanes
    typedef struct packed {
        logic                 is_cmp;
        logic                 is_mlog;
        logic [MAX_LANES-1:0] mlog;
    } t_ctl;

endpackage

`default_nettype wire

FILE: sv/simd_int32_vector_alu.sv
// four-lane signed 32-bit vector alu, fully pipelined, stream in and out
// pipeline: 35 register stages (operand stage, 32 divider stages, lane result
//   stage, merge/output stage)
// throughput: one item per cycle; the whole pipe stalls only while output is held
// reset: synchronous active-low i_rst_n clears the valid chain only
// depends on svalu_pkg and svalu_lane (which uses svalu_div)
`timescale 1ns / 1ps
`default_nettype none

module simd_int32_vector_alu (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input stream
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata: a_lane0..3, b_lane0..3, mask_a, mask_b
    input  wire logic [svalu_pkg::IN_DATA_W-1:0]   i_s_tdata,
    // tuser: kind
    input  wire logic [svalu_pkg::KIND_W-1:0]      i_s_tuser,
    // output stream
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // tdata: r_lane0..3, mask_out, all_set, any_set, none_set, zero pad
    output logic      [svalu_pkg::OUT_DATA_W-1:0]  o_m_tdata
);
    import svalu_pkg::*;

    localparam int CTL_DEPTH = LANE_DEPTH;
    localparam int B_BASE    = MAX_LANES * DATA_W;
    localparam int M_BASE    = 2 * MAX_LANES * DATA_W;

    // pipe enable: advance unless the output holds an untaken result
    logic                   en;
    logic [PIPE_DEPTH-1:0]  r_vld;
    logic [KIND_W-1:0]      kind;
    logic [MAX_LANES-1:0]   ma;
    logic [MAX_LANES-1:0]   mb;
    t_ctl                   n_ctl;
    t_ctl                   r_ctl [CTL_DEPTH];
    logic [DATA_W-1:0]      lane_res [MAX_LANES];
    logic [MAX_LANES-1:0]   lane_cmp;
    logic [MAX_LANES-1:0]   n_mask;
    logic [DATA_W-1:0]      r_lane [MAX_LANES];
    logic [MAX_LANES-1:0]   r_mask;

    assign en         = !r_vld[PIPE_DEPTH-1] || i_m_tready;
    assign o_s_tready = en;
    assign o_m_tvalid = r_vld[PIPE_DEPTH-1];

    assign kind = i_s_tuser;
    assign ma   = i_s_tdata[M_BASE +: MAX_LANES] & LANE_MASK;
    assign mb   = i_s_tdata[M_BASE + MAX_LANES +: MAX_LANES] & LANE_MASK;

    // valid chain, one bit per pipe stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_s_tvalid};
        end
    end

    // mask logic needs no lane data, computed at the input
    always_comb begin
        n_ctl.is_cmp  = (kind >= K_EQ) && (kind <= K_LT);
        n_ctl.is_mlog = (kind >= K_MNOT) && (kind <= K_MPASS);
        unique case (kind)
            K_MNOT:  n_ctl.mlog = ~ma;
            K_MAND:  n_ctl.mlog = ma & mb;
            K_MOR:   n_ctl.mlog = ma | mb;
            K_MXOR:  n_ctl.mlog = ma ^ mb;
            K_MEQ:   n_ctl.mlog = ~(ma ^ mb);
            K_MNE:   n_ctl.mlog = ma ^ mb;
            K_MPASS: n_ctl.mlog = ma;
            default: n_ctl.mlog = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ctl[0] <= n_ctl;
            for (int k = 1; k < CTL_DEPTH; k++) begin
                r_ctl[k] <= r_ctl[k-1];
            end
        end
    end

    // lanes side by side
    for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
        if (g < LANES) begin : g_on
            svalu_lane u_lane (
                .i_clk   (i_clk),
                .i_en    (en),
                .i_kind  (kind),
                .i_a     (i_s_tdata[g*DATA_W +: DATA_W]),
                .i_b     (i_s_tdata[B_BASE + g*DATA_W +: DATA_W]),
                .i_bcast (i_s_tdata[DATA_W-1:0]),
                .i_sel   (ma[g]),
                .o_res   (lane_res[g]),
                .o_cmp   (lane_cmp[g])
            );
        end else begin : g_off
            assign lane_res[g] = '0;
            assign lane_cmp[g] = 1'b0;
        end
    end

    // merge stage: lane compare bits or mask logic become the output mask
    always_comb begin
        if (r_ctl[CTL_DEPTH-1].is_cmp) begin
            n_mask = lane_cmp & LANE_MASK;
        end else if (r_ctl[CTL_DEPTH-1].is_mlog) begin
            n_mask = r_ctl[CTL_DEPTH-1].mlog & LANE_MASK;
        end else begin
            n_mask = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < MAX_LANES; k++) begin
                r_lane[k] <= lane_res[k];
            end
            r_mask <= n_mask;
        end
    end

    always_comb begin
        o_m_tdata = '0;
        for (int k = 0; k < MAX_LANES; k++) begin
            o_m_tdata[k*DATA_W +: DATA_W] = r_lane[k];
        end
        o_m_tdata[B_BASE +: MAX_LANES]  = r_mask;
        o_m_tdata[B_BASE + MAX_LANES]     = (r_mask == LANE_MASK);
        o_m_tdata[B_BASE + MAX_LANES + 1] = (r_mask != '0);
        o_m_tdata[B_BASE + MAX_LANES + 2] = (r_mask == '0);
    end

`ifndef ASSERT_OFF
    // any and none flags are always complementary on a delivered result
    a_any_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[B_BASE + MAX_LANES + 1] !=
                        o_m_tdata[B_BASE + MAX_LANES + 2]))
        else $error("any_set and none_set not complementary");

    // a mask-producing result carries zero lanes
    a_mask_zero_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_mask != '0)) |-> (o_m_tdata[B_BASE-1:0] == '0))
        else $error("nonzero lanes with a mask result");

    // a held output keeps the whole pipe frozen
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> $stable(r_vld))
        else $error("pipe advanced during output stall");

    // no mask bits beyond the active lanes
    a_lane_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((r_mask & ~LANE_MASK) == '0))
        else $error("mask bit set for an inactive lane");
`endif

endmodule

`default_nettype wire

FILE: sv/svalu_div.sv
// pipelined unsigned restoring divider, one quotient bit per stage
// depends on svalu_pkg
`timescale 1ns / 1ps
`default_nettype none

module svalu_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [svalu_pkg::DATA_W-1:0]  i_num,
    input  wire logic [svalu_pkg::DATA_W-1:0]  i_den,
    output logic      [svalu_pkg::DATA_W-1:0]  o_quo,
    output logic      [svalu_pkg::DATA_W-1:0]  o_rem
);
    import svalu_pkg::*;

    logic [DATA_W:0]   r_p  [DIV_STAGES];
    logic [DATA_W-1:0] r_nq [DIV_STAGES];
    logic [DATA_W-1:0] r_d  [DIV_STAGES];

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
        logic [DATA_W:0]   p_in;
        logic [DATA_W-1:0] nq_in;
        logic [DATA_W-1:0] d_in;
        logic [DATA_W:0]   sh;
        logic              ge;

        if (k == 0) begin : g_first
            assign p_in  = '0;
            assign nq_in = i_num;
            assign d_in  = i_den;
        end else begin : g_next
            assign p_in  = r_p[k-1];
            assign nq_in = r_nq[k-1];
            assign d_in  = r_d[k-1];
        end

        // shift in the next dividend bit, subtract when it fits
        assign sh = {p_in[DATA_W-1:0], nq_in[DATA_W-1]};
        assign ge = (sh >= {1'b0, d_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_p[k]  <= ge ? (sh - {1'b0, d_in}) : sh;
                r_nq[k] <= {nq_in[DATA_W-2:0], ge};
                r_d[k]  <= d_in;
            end
        end
    end

    assign o_quo = r_nq[DIV_STAGES-1];
    assign o_rem = r_p[DIV_STAGES-1][DATA_W-1:0];

endmodule

`default_nettype wire

FILE: sv/svalu_lane.sv
// one 32-bit lane: operand stage, pipelined divider, result stage
// depends on svalu_pkg and svalu_div
`timescale 1ns / 1ps
`default_nettype none

module svalu_lane (
    input  wire logic                          i_clk,
    input  wire logic                          i_en,
    input  wire logic [svalu_pkg::KIND_W-1:0]  i_kind,
    input  wire logic [svalu_pkg::DATA_W-1:0]  i_a,
    input  wire logic [svalu_pkg::DATA_W-1:0]  i_b,
    input  wire logic [svalu_pkg::DATA_W-1:0]  i_bcast,
    input  wire logic                          i_sel,
    output logic      [svalu_pkg::DATA_W-1:0]  o_res,
    output logic                               o_cmp
);
    import svalu_pkg::*;

    logic [DATA_W-1:0] n_val;
    logic              n_cmp;
    logic [DATA_W-1:0] a_mag;
    logic [DATA_W-1:0] b_mag;
    logic [DATA_W-1:0] mul_lo;

    t_side             r_pre;
    logic [DATA_W-1:0] r_an;
    logic [DATA_W-1:0] r_bn;
    logic              r_cmp0;
    t_side             r_side [DIV_STAGES];
    logic              r_cmpl [DIV_STAGES];
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] rem;
    logic [DATA_W-1:0] q_fix;
    logic [DATA_W-1:0] r_fix;
    logic [DATA_W-1:0] r_res;
    logic              r_cmp;

    assign mul_lo = i_a * i_b;
    assign a_mag  = i_a[DATA_W-1] ? (~i_a + 1'b1) : i_a;
    assign b_mag  = i_b[DATA_W-1] ? (~i_b + 1'b1) : i_b;

    always_comb begin
        n_val = '0;
        n_cmp = 1'b0;
        unique case (i_kind)
            K_BCAST: n_val = i_bcast;
            K_NOT:   n_val = ~i_a;
            K_NEG:   n_val = ~i_a + 1'b1;
            K_ADD:   n_val = i_a + i_b;
            K_SUB:   n_val = i_a - i_b;
            K_MUL:   n_val = mul_lo;
            K_AND:   n_val = i_a & i_b;
            K_OR:    n_val = i_a | i_b;
            K_XOR:   n_val = i_a ^ i_b;
            K_SHL:   n_val = i_a << i_b[4:0];
            K_SAR:   n_val = DATA_W'($signed(i_a) >>> i_b[4:0]);
            K_EQ:    n_cmp = (i_a == i_b);
            K_NE:    n_cmp = (i_a != i_b);
            K_GE:    n_cmp = ($signed(i_a) >= $signed(i_b));
            K_LE:    n_cmp = ($signed(i_a) <= $signed(i_b));
            K_GT:    n_cmp = ($signed(i_a) > $signed(i_b));
            K_LT:    n_cmp = ($signed(i_a) < $signed(i_b));
            K_SEL:   n_val = i_sel ? i_b : i_a;
            default: n_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pre.val    <= n_val;
            r_pre.a      <= i_a;
            r_pre.is_div <= (i_kind == K_DIV);
            r_pre.is_rem <= (i_kind == K_REM);
            r_pre.dz     <= (i_b == '0);
            r_pre.neg_q  <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            r_pre.neg_r  <= i_a[DATA_W-1];
            r_an         <= a_mag;
            r_bn         <= b_mag;
            r_cmp0       <= n_cmp;
        end
    end

    svalu_div u_div (
        .i_clk (i_clk),
        .i_en  (i_en),
        .i_num (r_an),
        .i_den (r_bn),
        .o_quo (quo),
        .o_rem (rem)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_side[0] <= r_pre;
            r_cmpl[0] <= r_cmp0;
            for (int k = 1; k < DIV_STAGES; k++) begin
                r_side[k] <= r_side[k-1];
                r_cmpl[k] <= r_cmpl[k-1];
            end
        end
    end

    // sign fix; zero divisor overrides, min over minus one wraps by itself
    always_comb begin
        q_fix = r_side[DIV_STAGES-1].neg_q ? (~quo + 1'b1) : quo;
        r_fix = r_side[DIV_STAGES-1].neg_r ? (~rem + 1'b1) : rem;
        if (r_side[DIV_STAGES-1].dz) begin
            q_fix = '1;
            r_fix = r_side[DIV_STAGES-1].a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= r_side[DIV_STAGES-1].is_div ? q_fix :
                     r_side[DIV_STAGES-1].is_rem ? r_fix : r_side[DIV_STAGES-1].val;
            r_cmp <= r_cmpl[DIV_STAGES-1];
        end
    end

    assign o_res = r_res;
    assign o_cmp = r_cmp;

endmodule

`default_nettype wire
